// ----- rtl/top_n_retain_min_heap_defines.svh -----
// Assertion macros used by the heap selector RTL.
`ifndef TOP_N_RETAIN_MIN_HEAP_DEFINES_SVH
`define TOP_N_RETAIN_MIN_HEAP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TNRMH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TNRMH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TNRMH_ASSERT(label, prop, msg)
`define TNRMH_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- rtl/tnrmh_pkg.sv -----
`default_nettype none

package tnrmh_pkg;

  localparam int unsigned DataW          = 32;
  localparam int unsigned CfgW           = 11;
  localparam int unsigned HeapSizeDflt   = 1024;
  localparam int unsigned CfgResetCount  = 1024;

  // Signed less-than on two data words.
  function automatic logic s_lt(input logic signed [DataW-1:0] a,
                                input logic signed [DataW-1:0] b);
    return a < b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/top_n_retain_min_heap.sv -----
`default_nettype none

// Keeps the retained_count largest signed values seen so far in a binary
// min-heap held in one single-port-read, single-port-write memory. The first
// retained_count beats fill the store (no result); the beat that fills it
// starts a bottom-up heap build of about count/2 sift-downs, during which no
// input is taken. After that a value below the heap minimum passes straight
// through, and a value at or above it evicts the minimum and is sifted down
// from the root: the beat is accepted, then each heap level takes a left read,
// a right read and a compare and write, and a final write settles the value.
// The one memory read port, used once per child, makes the two reads serial.
// Writing retained_count restarts the selection with an empty store.
module top_n_retain_min_heap
  import tnrmh_pkg::*;
#(
  parameter int unsigned HEAP_SIZE = HeapSizeDflt
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    retained_count_we_i,
  input  wire logic [CfgW-1:0]         retained_count_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [DataW-1:0] value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [DataW-1:0]      passed_value_o,
  output logic                         from_store_o
);

`include "top_n_retain_min_heap_defines.svh"

  localparam int unsigned AddrW    = $clog2(HEAP_SIZE);
  localparam int unsigned CntW     = $clog2(HEAP_SIZE + 1);
  localparam int unsigned ChildW   = AddrW + 2;
  localparam int unsigned ResetCnt =
      (CfgResetCount > HEAP_SIZE) ? HEAP_SIZE : CfgResetCount;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BNEXT,
    S_BLOAD,
    S_CHK,
    S_RDL,
    S_RDR
  } state_e;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         fill_q, fill_d;
  logic                    built_q, built_d;
  logic                    building_q, building_d;
  logic [AddrW-1:0]        n_q, n_d;
  logic [AddrW-1:0]        pos_q, pos_d;
  logic signed [DataW-1:0] sv_q, sv_d;
  logic signed [DataW-1:0] best_q, best_d;
  logic                    take_l_q, take_l_d;
  logic signed [DataW-1:0] root_q, root_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [DataW-1:0] pv_q, pv_d;
  logic                    fs_q, fs_d;

  // Heap memory.
  logic signed [DataW-1:0] mem [HEAP_SIZE];
  logic                    mem_we;
  logic [AddrW-1:0]        mem_wa;
  logic signed [DataW-1:0] mem_wd;
  logic                    rd_en;
  logic [AddrW-1:0]        rd_addr;
  logic signed [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  logic              in_accept;
  logic              sifting;
  logic [31:0]       cfg_wide;
  logic [CntW-1:0]   cfg_eff;
  logic [ChildW-1:0] pos_w, cnt_w, lc_w, rc_w;
  logic              has_kids, has_rc;
  logic [CntW-1:0]   fill_inc;

  // A count write takes the cycle, so no beat is taken alongside it.
  assign in_ready_o     = (state_q == S_IDLE) && !retained_count_we_i &&
                          (!out_valid_q || out_ready_i);
  assign in_accept      = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign passed_value_o = pv_q;
  assign from_store_o   = fs_q;
  assign sifting        = (state_q == S_CHK) || (state_q == S_RDL) ||
                          (state_q == S_RDR);

  assign pos_w    = ChildW'(pos_q);
  assign cnt_w    = ChildW'(cnt_q);
  assign lc_w     = (pos_w << 1) + ChildW'(1);
  assign rc_w     = lc_w + ChildW'(1);
  assign has_kids = pos_w < (cnt_w >> 1);
  assign has_rc   = rc_w < cnt_w;
  assign fill_inc = fill_q + CntW'(1);

  // A count of zero acts as one; a count above the store depth is clipped.
  always_comb begin
    cfg_wide = 32'(retained_count_i);
    if (cfg_wide == 32'd0) begin
      cfg_eff = CntW'(1);
    end else if (cfg_wide > 32'(HEAP_SIZE)) begin
      cfg_eff = CntW'(HEAP_SIZE);
    end else begin
      cfg_eff = CntW'(cfg_wide);
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    built_d     = built_q;
    building_d  = building_q;
    n_d         = n_q;
    pos_d       = pos_q;
    sv_d        = sv_q;
    best_d      = best_q;
    take_l_d    = take_l_q;
    out_valid_d = out_valid_q;
    pv_d        = pv_q;
    fs_d        = fs_q;
    mem_we      = 1'b0;
    mem_wa      = pos_q;
    mem_wd      = sv_q;
    rd_en       = 1'b0;
    rd_addr     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (!built_q) begin
            mem_we = 1'b1;
            mem_wa = fill_q[AddrW-1:0];
            mem_wd = value_i;
            fill_d = fill_inc;
            if (fill_inc >= cnt_q) begin
              n_d        = AddrW'(cnt_q >> 1);
              building_d = 1'b1;
              state_d    = S_BNEXT;
            end
          end else if (!s_lt(value_i, root_q)) begin
            out_valid_d = 1'b1;
            pv_d        = root_q;
            fs_d        = 1'b1;
            sv_d        = value_i;
            pos_d       = '0;
            building_d  = 1'b0;
            state_d     = S_CHK;
          end else begin
            out_valid_d = 1'b1;
            pv_d        = value_i;
            fs_d        = 1'b0;
          end
        end
      end
      S_BNEXT: begin
        if (n_q == '0) begin
          built_d    = 1'b1;
          building_d = 1'b0;
          state_d    = S_IDLE;
        end else begin
          n_d     = n_q - AddrW'(1);
          rd_en   = 1'b1;
          rd_addr = n_q - AddrW'(1);
          state_d = S_BLOAD;
        end
      end
      S_BLOAD: begin
        sv_d    = rd_data_q;
        pos_d   = n_q;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (has_kids) begin
          rd_en   = 1'b1;
          rd_addr = lc_w[AddrW-1:0];
          state_d = S_RDL;
        end else begin
          // Leaf reached: the sifted value settles here.
          mem_we  = 1'b1;
          state_d = building_q ? S_BNEXT : S_IDLE;
        end
      end
      S_RDL: begin
        if (s_lt(rd_data_q, sv_q)) begin
          best_d   = rd_data_q;
          take_l_d = 1'b1;
        end else begin
          best_d   = sv_q;
          take_l_d = 1'b0;
        end
        if (has_rc) begin
          rd_en   = 1'b1;
          rd_addr = rc_w[AddrW-1:0];
        end
        state_d = S_RDR;
      end
      S_RDR: begin
        // The right child wins only if strictly smaller, so ties keep the left.
        if (has_rc && s_lt(rd_data_q, best_q)) begin
          mem_we  = 1'b1;
          mem_wd  = rd_data_q;
          pos_d   = rc_w[AddrW-1:0];
          state_d = S_CHK;
        end else if (take_l_q) begin
          mem_we  = 1'b1;
          mem_wd  = best_q;
          pos_d   = lc_w[AddrW-1:0];
          state_d = S_CHK;
        end else begin
          mem_we  = 1'b1;
          state_d = building_q ? S_BNEXT : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A count write restarts the selection from any state; the store is
    // refilled from entry zero, so an abandoned build or sift does no harm.
    if (retained_count_we_i) begin
      cnt_d      = cfg_eff;
      fill_d     = '0;
      built_d    = 1'b0;
      building_d = 1'b0;
      state_d    = S_IDLE;
    end

    // The root is mirrored in a register so an incoming beat compares at once.
    root_d = root_q;
    if (mem_we && (mem_wa == '0)) begin
      root_d = mem_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= CntW'(ResetCnt);
      fill_q      <= '0;
      built_q     <= 1'b0;
      building_q  <= 1'b0;
      n_q         <= '0;
      pos_q       <= '0;
      sv_q        <= '0;
      best_q      <= '0;
      take_l_q    <= 1'b0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
      pv_q        <= '0;
      fs_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      built_q     <= built_d;
      building_q  <= building_d;
      n_q         <= n_d;
      pos_q       <= pos_d;
      sv_q        <= sv_d;
      best_q      <= best_d;
      take_l_q    <= take_l_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
      pv_q        <= pv_d;
      fs_q        <= fs_d;
    end
  end

  `TNRMH_ASSERT(a_fill_bound, fill_q <= cnt_q, "fill count passed the retained count")
  `TNRMH_ASSERT(a_sift_pos, sifting |-> (pos_w < cnt_w), "sift position left the heap")
  `TNRMH_ASSERT(a_result_follows, (in_accept && built_q) |=> out_valid_o, "no result for a beat")

endmodule

`default_nettype wire

// ----- dv/tb_top_n_retain_min_heap.sv -----
`default_nettype none

module tb_top_n_retain_min_heap;
  timeunit 1ns;
  timeprecision 1ps;

  import tnrmh_pkg::*;

  localparam int unsigned HeapDepth = HeapSizeDflt;
  localparam logic signed [DataW-1:0] ValueMin = 32'sh8000_0000;
  localparam logic signed [DataW-1:0] ValueMax = 32'sh7fff_ffff;
  localparam int unsigned RandomItems = 450;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    from_store;
  } reject_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    retained_count_we_i = 1'b0;
  logic [CfgW-1:0]         retained_count_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [DataW-1:0] value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DataW-1:0] passed_value_o;
  logic                    from_store_o;

  // Values waiting to be offered, and rejections the kept set must still give up.
  logic signed [DataW-1:0] pending_values[$];
  reject_t                 rejects_due[$];

  // Predicted heap contents and selection state.
  logic signed [DataW-1:0] heap_mdl[HeapDepth];
  int unsigned             fill_mdl = 0;
  bit                      built_mdl = 1'b0;
  logic [CfgW-1:0]         count_reg = CfgResetCount;

  int unsigned             gap_pct = 8;
  int unsigned             stall_pct = 8;
  int unsigned             mismatches = 0;
  int unsigned             random_items = 0;
  logic signed [DataW-1:0] ramp_val = '0;

  top_n_retain_min_heap dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .retained_count_we_i(retained_count_we_i),
    .retained_count_i   (retained_count_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .value_i            (value_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .passed_value_o     (passed_value_o),
    .from_store_o       (from_store_o)
  );

  always #2 clk_i = ~clk_i;

  // A count of zero keeps one value; counts above the store size are clipped.
  function automatic int unsigned active_count();
    int unsigned c;
    c = count_reg;
    if (c == 0) c = 1;
    if (c > HeapDepth) c = HeapDepth;
    return c;
  endfunction

  // Sift-down: a child moves up only if strictly smaller, the left child wins ties.
  function automatic void sift_mdl(input int unsigned node, input int unsigned cnt);
    int unsigned pos;
    int unsigned here;
    int unsigned lc;
    int unsigned rc;
    logic signed [DataW-1:0] t;
    pos = node;
    while (pos < cnt / 2) begin
      here = pos;
      lc = 2 * here + 1;
      rc = 2 * here + 2;
      if (lc < cnt && heap_mdl[lc] < heap_mdl[pos]) pos = lc;
      if (rc < cnt && heap_mdl[rc] < heap_mdl[pos]) pos = rc;
      if (pos == here) break;
      t = heap_mdl[here];
      heap_mdl[here] = heap_mdl[pos];
      heap_mdl[pos] = t;
    end
  endfunction

  function automatic void select_top(input logic signed [DataW-1:0] v);
    int unsigned cnt;
    reject_t r;
    cnt = active_count();
    if (!built_mdl) begin
      if (fill_mdl < cnt) begin
        heap_mdl[fill_mdl] = v;
        fill_mdl++;
      end
      if (fill_mdl >= cnt) begin
        for (int unsigned n = cnt / 2; n > 0; n--) sift_mdl(n - 1, cnt);
        built_mdl = 1'b1;
      end
    end else if (!(v < heap_mdl[0])) begin
      r.value = heap_mdl[0];
      r.from_store = 1'b1;
      rejects_due.push_back(r);
      heap_mdl[0] = v;
      sift_mdl(0, cnt);
    end else begin
      r.value = v;
      r.from_store = 1'b0;
      rejects_due.push_back(r);
    end
  endfunction

  // Covers a full heap build plus one root sift-down at the current count.
  function automatic int unsigned quiet_cycles();
    int unsigned c;
    c = active_count();
    return (c / 2 + 1) * (3 * $clog2(c + 1) + 2) + 64;
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 35) begin
      return $urandom;
    end else if (sel < 65) begin
      // A narrow range gives many ties with the root and between children.
      return $signed($urandom_range(16)) - 8;
    end else if (sel < 75) begin
      case ($urandom_range(3))
        0: return ValueMin;
        1: return ValueMax;
        2: return '0;
        default: return -1;
      endcase
    end else begin
      // A rising run keeps evicting the minimum and drives deep sift-downs.
      ramp_val = ramp_val + $signed($urandom_range(3));
      return ramp_val;
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) select_top(value_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_values.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_valid_i <= 1'b1;
          value_i <= pending_values.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    reject_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rejects_due.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result beat: passed_value %0d from_store %0b",
                   passed_value_o, from_store_o);
        end
        mismatches++;
      end else begin
        want = rejects_due.pop_front();
        if (passed_value_o !== want.value || from_store_o !== want.from_store) begin
          if (mismatches < 10) begin
            $display("result mismatch: passed_value exp %0d got %0d, from_store exp %0b got %0b",
                     want.value, passed_value_o, want.from_store, from_store_o);
          end
          mismatches++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_values.size() != 0 || in_valid_i || rejects_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Items that fill the store give no result, so the heap build may still be
  // running once the last result is out.
  task automatic settle();
    drain();
    repeat (quiet_cycles()) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CfgW-1:0] c);
    @(posedge clk_i);
    retained_count_we_i <= 1'b1;
    retained_count_i <= c;
    count_reg = c;
    fill_mdl = 0;
    built_mdl = 1'b0;
    @(posedge clk_i);
    retained_count_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_phase(input bit with_pause);
    logic [CfgW-1:0] cnt;
    int unsigned sel;
    int unsigned eff;
    int unsigned total;
    sel = $urandom_range(99);
    if (sel < 10) cnt = '0;
    else if (sel < 20) cnt = CfgW'($urandom_range(150, 25));
    else cnt = CfgW'($urandom_range(24, 1));
    write_count(cnt);
    eff = active_count();
    // Now and then the count is rewritten while the store is only partly filled.
    if ($urandom_range(5) == 0) total = $urandom_range(eff - 1);
    else total = eff + $urandom_range(30, 4);
    for (int unsigned n = 0; n < total; n++) begin
      if (with_pause && n == total / 2) drain();
      pending_values.push_back(pick_value());
    end
    settle();
    random_items += total;
  endtask

  initial begin
    #4_000_000;
    $display("** top_n_retain_min_heap: FAILED **");
    $finish;
  end

  initial begin
    int phase;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Count left at its reset value: a partial fill gives no result.
    for (int n = 0; n < 40; n++) pending_values.push_back(pick_value());
    settle();

    // Count of zero keeps a single value; ties with the root evict it.
    write_count('0);
    pending_values.push_back(ValueMin);
    pending_values.push_back(ValueMax);
    pending_values.push_back(ValueMax);
    pending_values.push_back('0);
    pending_values.push_back(ValueMin);
    settle();

    write_count(CfgW'(2));
    pending_values.push_back('0);
    pending_values.push_back(-1);
    pending_values.push_back(-1);
    pending_values.push_back(32'sd5);
    settle();

    // Equal children under each node exercise the left-first tie rule.
    write_count(CfgW'(7));
    pending_values.push_back(32'sd9);
    pending_values.push_back(32'sd3);
    pending_values.push_back(32'sd3);
    for (int n = 0; n < 4; n++) pending_values.push_back(32'sd4);
    pending_values.push_back(32'sd10);
    pending_values.push_back(32'sd3);
    // The sender waits here until every result so far is out.
    drain();
    pending_values.push_back(32'sd4);
    pending_values.push_back(ValueMax);
    pending_values.push_back(ValueMin);
    settle();

    // Largest register value is clipped to the store size; a partial fill
    // gives no result.
    write_count({CfgW{1'b1}});
    for (int n = 0; n < 40; n++) pending_values.push_back(pick_value());
    settle();

    phase = 0;
    while (random_items < RandomItems) begin
      if (phase == 2) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = 8;
        stall_pct = 8;
      end
      random_phase(phase % 3 == 1);
      phase++;
    end

    settle();
    if (mismatches == 0 && rejects_due.size() == 0) begin
      $display("** top_n_retain_min_heap: PASSED **");
    end else begin
      $display("** top_n_retain_min_heap: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
